// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies another one in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bfsm_pkg.sv =====
// Types, constants and the probe multiplier table of the Bloom filter.
package bfsm_pkg;

	localparam int HC_W = 5;
	localparam int FILL_W = 11;
	localparam int BITS_SET_W = 17;
	localparam int CFG_INDEX_W = 4;
	localparam int WORD_BITS = 32;
	localparam int WORD_SHIFT = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int MULT_TAB_DEPTH = 32;

	localparam logic [31:0] FP_START = 32'd5381;
	localparam logic [31:0] PROBE_BASE = 32'd17;
	localparam int FP_SHIFT = 5;

	localparam logic [CFG_INDEX_W-1:0] REG_HASH_COUNT = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FILL_FACTOR = 4'd1;
	localparam logic [HC_W-1:0] HASH_COUNT_RESET = 5'd3;
	localparam logic [FILL_W-1:0] FILL_FACTOR_RESET = 11'd2;

	typedef struct packed {
		logic mode;
		logic [7:0] char_byte;
		logic is_last;
	} in_item_t;

	typedef struct packed {
		logic member;
		logic [BITS_SET_W-1:0] bits_set;
		logic full_res;
	} out_item_t;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [FILL_W-1:0] wdata;
	} cfg_write_t;

	typedef struct packed {
		logic [HC_W-1:0] hash_count;
		logic [FILL_W-1:0] fill_factor;
	} cfg_regs_t;

	// One finished string handed from the front to the back.
	typedef struct packed {
		logic mode;
		logic [31:0] fp;
	} job_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL,
		S_READ,
		S_UPDATE,
		S_FULL,
		S_EMIT
	} back_state_t;

	typedef logic [MULT_TAB_DEPTH-1:0][31:0] mult_tab_t;

	// Entry k holds 17^(2^k) mod 2^32, built by repeated squaring.
	function automatic mult_tab_t build_mult_tab();
		mult_tab_t tab;
		logic [63:0] sq;
		tab[0] = PROBE_BASE;
		for (int i = 1; i < MULT_TAB_DEPTH; i++) begin
			sq = {32'd0, tab[i-1]} * {32'd0, tab[i-1]};
			tab[i] = sq[31:0];
		end
		return tab;
	endfunction

	localparam mult_tab_t MULT_TAB = build_mult_tab();

endpackage

// ===== rtl/core/bfsm_stream_if.sv =====
// Valid/ready channel interface with a typed payload.
interface bfsm_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/bfsm_front.sv =====
// Front end: takes string bytes and folds them into the running fingerprint.
module bfsm_front import bfsm_pkg::*; (
	input logic clk,
	input logic arst_n,
	bfsm_stream_if.sink item,
	input logic clearing,
	input logic job_room,
	output logic job_push,
	output job_t job
);

	logic [31:0] fp_q;
	logic [31:0] fp_next;
	logic [31:0] char_ext;
	logic accept;

	assign item.ready = !clearing && job_room;
	assign accept = item.valid && item.ready;

	// The byte enters the hash as a sign-extended char.
	assign char_ext = {{24{item.data.char_byte[7]}}, item.data.char_byte};
	assign fp_next = ((fp_q << FP_SHIFT) + fp_q) ^ char_ext;

	assign job_push = accept && item.data.is_last;
	assign job = '{mode: item.data.mode, fp: fp_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q <= FP_START;
		end else if (accept) begin
			fp_q <= item.data.is_last ? FP_START : fp_next;
		end
	end

endmodule

// ===== rtl/core/bfsm_queue.sv =====
// Short queue of finished strings between the front and the back.
module bfsm_queue import bfsm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input job_t push_job,
	output logic room,
	input logic pop,
	output logic head_valid,
	output job_t head_job
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign room = count_q != CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_job = entries_q[rd_ptr_q];
	assign do_push = push && room;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/bfsm_back.sv =====
// Back end: probes the bit memory for each string and produces the result.
module bfsm_back import bfsm_pkg::*; #(
	parameter int FILTER_BITS = 65536
) (
	input logic clk,
	input logic arst_n,
	input cfg_regs_t cfg_regs,
	input logic job_valid,
	input job_t job,
	output logic job_pop,
	output logic clearing,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data
);

	localparam int LOG_BITS = $clog2(FILTER_BITS);
	localparam int ROWS = FILTER_BITS / WORD_BITS;
	localparam int ROW_W = LOG_BITS - WORD_SHIFT;
	localparam int CNT_W = LOG_BITS + 1;
	localparam int PROD_W = CNT_W + FILL_W;

	back_state_t state_q, state_d;
	logic [ROW_W-1:0] clear_row_q;
	logic mode_q;
	logic miss_q;
	logic [31:0] fp_q;
	logic [HC_W-1:0] k_q;
	logic [LOG_BITS-1:0] pos_q;
	logic [WORD_BITS-1:0] rdata_q;
	logic [CNT_W-1:0] count_q;
	logic [PROD_W-1:0] prod_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [WORD_BITS-1:0] mem [ROWS];

	logic [31:0] probe_prod;
	logic cur_bit;
	logic probe_done;
	logic clear_done;
	logic emit;
	logic mem_we;
	logic mem_re;
	logic [ROW_W-1:0] mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic count_inc;
	logic miss_set;

	assign probe_prod = fp_q * MULT_TAB[k_q];
	assign cur_bit = rdata_q[pos_q[WORD_SHIFT-1:0]];
	assign probe_done = ((HC_W+1)'(k_q) + (HC_W+1)'(1)) == (HC_W+1)'(cfg_regs.hash_count);
	assign clear_done = clear_row_q == ROW_W'(ROWS - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (job_valid) begin
					state_d = (cfg_regs.hash_count == '0) ? S_FULL : S_MUL;
				end
			end
			S_MUL: state_d = S_READ;
			S_READ: state_d = S_UPDATE;
			S_UPDATE: state_d = probe_done ? S_FULL : S_MUL;
			S_FULL: state_d = S_EMIT;
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		clearing = 1'b0;
		job_pop = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_waddr = pos_q[LOG_BITS-1:WORD_SHIFT];
		mem_wdata = rdata_q | (WORD_BITS'(1) << pos_q[WORD_SHIFT-1:0]);
		count_inc = 1'b0;
		miss_set = 1'b0;
		emit = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				clearing = 1'b1;
				mem_we = 1'b1;
				mem_waddr = clear_row_q;
				mem_wdata = '0;
			end
			S_IDLE: job_pop = job_valid;
			S_MUL: ;
			S_READ: mem_re = 1'b1;
			S_UPDATE: begin
				if (!cur_bit) begin
					if (mode_q) begin
						miss_set = 1'b1;
					end else begin
						mem_we = 1'b1;
						count_inc = 1'b1;
					end
				end
			end
			S_FULL: ;
			S_EMIT: emit = !out_valid_q || out_ready;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[pos_q[LOG_BITS-1:WORD_SHIFT]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clear_row_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clear_row_q <= clear_row_q + ROW_W'(1);
			end
			if (count_inc) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			mode_q <= job.mode;
			fp_q <= job.fp;
			k_q <= '0;
			miss_q <= 1'b0;
		end else begin
			if (state_q == S_UPDATE) begin
				k_q <= k_q + HC_W'(1);
			end
			if (miss_set) begin
				miss_q <= 1'b1;
			end
		end
		if (state_q == S_MUL) begin
			pos_q <= probe_prod[LOG_BITS-1:0];
		end
		if (state_q == S_FULL) begin
			prod_q <= PROD_W'(count_q) * PROD_W'(cfg_regs.fill_factor);
		end
		if (emit) begin
			out_q.member <= mode_q && !miss_q;
			out_q.bits_set <= BITS_SET_W'(count_q);
			out_q.full_res <= prod_q >= PROD_W'(FILTER_BITS);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// ===== rtl/core/bloom_filter_string_membership_top.sv =====
// Channel   Dir  Payload                              Transfer
// item      in   mode, char_byte, is_last             valid && ready
// result    out  member, bits_set, full_res           valid && ready
// cfg       in   index, wdata (0 hash_count, 1 fill)  valid && ready
//
// The front takes one byte per cycle unless stalled; the byte that ends a string
// goes to a two-entry queue. For each string the back runs the multiply, the
// registered memory read and the read-modify-write once per probe.
// After reset the bit memory is cleared one 32-bit row per cycle, and no byte is
// taken until that pass ends; cfg writes are always taken.
// A full queue stalls the byte input; a waiting result stalls only the back.
// FILTER_BITS must be a power of two.
module bloom_filter_string_membership_top import bfsm_pkg::*; #(
	parameter int FILTER_BITS = 65536
) (
	input logic clk,
	input logic arst_n,
	bfsm_stream_if.sink item,
	bfsm_stream_if.source result,
	bfsm_stream_if.sink cfg
);

	`include "assert_macros.svh"

	cfg_regs_t cfg_regs_q;
	logic clearing;
	logic job_push;
	logic job_room;
	job_t push_job;
	logic job_valid;
	logic job_pop;
	job_t head_job;
	logic out_valid;
	out_item_t out_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs_q.hash_count <= HASH_COUNT_RESET;
			cfg_regs_q.fill_factor <= FILL_FACTOR_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.data.index)
				REG_HASH_COUNT: cfg_regs_q.hash_count <= cfg.data.wdata[HC_W-1:0];
				REG_FILL_FACTOR: cfg_regs_q.fill_factor <= cfg.data.wdata;
				default: ;
			endcase
		end
	end

	bfsm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.clearing(clearing),
		.job_room(job_room),
		.job_push(job_push),
		.job(push_job)
	);

	bfsm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_push),
		.push_job(push_job),
		.room(job_room),
		.pop(job_pop),
		.head_valid(job_valid),
		.head_job(head_job)
	);

	bfsm_back #(.FILTER_BITS(FILTER_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_regs(cfg_regs_q),
		.job_valid(job_valid),
		.job(head_job),
		.job_pop(job_pop),
		.clearing(clearing),
		.out_valid(out_valid),
		.out_ready(result.ready),
		.out_data(out_data)
	);

	assign result.valid = out_valid;
	assign result.data = out_data;

	`ASSERT_ALWAYS(a_no_byte_while_clearing, clk, arst_n, !(clearing && item.ready), "byte taken during clear")
	`ASSERT_ALWAYS(a_no_result_while_clearing, clk, arst_n, !(clearing && result.valid), "result during clear")
	`ASSERT_ALWAYS(a_push_has_room, clk, arst_n, !job_push || job_room, "string end lost at full queue")
	`ASSERT_NEXT(a_pop_leaves_idle, clk, arst_n, job_pop, !job_pop, "queue popped twice in a row")

endmodule
